// ===== hdl/smf_pkg.sv =====
// Shared types and constants for the sliding median filter.
// No dependencies; imported by every module in hdl/.
package smf_pkg;

    localparam int MAX_WINDOW  = 7;
    localparam int SAMPLE_BITS = 24;
    localparam int CFG_W       = 3;
    localparam int HALF_MAX    = (MAX_WINDOW - 1) / 2;
    localparam int H_W         = $clog2(HALF_MAX + 1);
    localparam int OFF_W       = $clog2(MAX_WINDOW);
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int RANK_W      = $clog2(MAX_WINDOW);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(7);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] t_window;

    // Control that travels with one window through the median pipe.
    typedef struct packed {
        logic [MAX_WINDOW-1:0] mask;   // slots taking part in the median
        logic [H_W-1:0]        half;   // rank of the median among valid slots
        logic                  last;   // final result of the sequence
    } t_win_ctl;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } t_state;

endpackage

// ===== hdl/sliding_median_filter_unit.sv =====
// Sliding median filter, top level: sample cell chain, sequence control,
// window select stage and median pipe. Depends on smf_pkg, smf_cell, smf_median.
// Pipeline: window select, compare and output registers (3 register stages) lie before o_m_tvalid.
// Throughput: one sample per cycle while the output is not stalled; a last sample that
//   flushes n results holds off input until the other n-1 are issued (one window select per cycle).
// Reset: synchronous, active low; clears control and sets window_size to 7.
module sliding_median_filter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input samples
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [smf_pkg::SAMPLE_BITS-1:0] i_s_tdata,  // [23:0] sample_value
    input  logic                            i_s_tlast,  // last_in_sequence
    // filtered results
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [smf_pkg::SAMPLE_BITS-1:0] o_m_tdata,  // [23:0] filtered_value
    output logic                            o_m_tlast,  // last_of_sequence
    // window_size register
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [smf_pkg::CFG_W-1:0]       i_cfg_data
);
    import smf_pkg::*;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_cfg;
    logic [CFG_W-1:0] half_full;
    logic [H_W-1:0]   half;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // half width: even sizes round down, zero acts as one, clamp to the chain
    assign half_full = (r_cfg == '0) ? '0 : ((r_cfg - 1'b1) >> 1);
    assign half = (half_full > CFG_W'(HALF_MAX)) ? H_W'(HALF_MAX) : half_full[H_W-1:0];

    // ---------------- control ----------------
    t_state           r_state;
    t_state           n_state;
    logic             r_open;       // a sequence is in progress
    logic             n_open;
    logic [CNT_W-1:0] r_seen;       // samples taken, saturating
    logic [CNT_W-1:0] n_seen;
    logic [H_W-1:0]   r_d;          // next flush delay
    logic [H_W-1:0]   n_d;

    logic             s1_ready;
    logic             accept;
    logic             first;
    logic [CNT_W-1:0] k;            // index of the incoming sample
    logic [H_W-1:0]   d0;           // delay of the oldest pending position

    logic             issue;
    logic [H_W-1:0]   issue_d;
    logic             issue_last;

    assign o_s_tready = (r_state == ST_RUN) && s1_ready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign first      = !r_open;
    assign k          = first ? '0 : r_seen;
    assign d0         = (k < CNT_W'(half)) ? H_W'(k) : half;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (accept && i_s_tlast && d0 != '0) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (s1_ready && r_d == '0) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_comb begin
        issue      = 1'b0;
        issue_d    = half;
        issue_last = 1'b0;
        n_open     = r_open;
        n_seen     = r_seen;
        n_d        = r_d;
        unique case (r_state)
            ST_RUN: begin
                if (accept) begin
                    if (i_s_tlast) begin
                        // emit every pending position, oldest first
                        issue      = 1'b1;
                        issue_d    = d0;
                        issue_last = (d0 == '0);
                        n_open     = 1'b0;
                        n_seen     = '0;
                        if (d0 != '0) begin
                            n_d = d0 - 1'b1;
                        end
                    end else begin
                        issue  = (k >= CNT_W'(half));
                        n_open = 1'b1;
                        n_seen = (k < CNT_W'(MAX_WINDOW)) ? k + 1'b1 : k;
                    end
                end
            end
            ST_FLUSH: begin
                if (s1_ready) begin
                    issue      = 1'b1;
                    issue_d    = r_d;
                    issue_last = (r_d == '0);
                    if (r_d != '0) begin
                        n_d = r_d - 1'b1;
                    end
                end
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_open  <= 1'b0;
            r_seen  <= '0;
            r_d     <= '0;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            r_seen  <= n_seen;
            r_d     <= n_d;
        end
    end

    // ---------------- sample cell chain, newest at cell 0 ----------------
    t_window hist;
    t_window n_hist;

    for (genvar c = 0; c < MAX_WINDOW; c++) begin : g_cell
        t_sample prev;
        if (c == 0) begin : g_head
            assign prev = t_sample'(i_s_tdata);
        end else begin : g_body
            assign prev = t_sample'(hist[c-1]);
        end
        smf_cell u_cell (
            .i_clk    (i_clk),
            .i_load   (accept && first),
            .i_shift  (accept && !first),
            .i_sample (t_sample'(i_s_tdata)),
            .i_prev   (prev),
            .o_val    (hist[c]),
            .o_next   (n_hist[c])
        );
    end

    // ---------------- window select (stage 1) ----------------
    // Slot t reads the cell d+h-t back; positions newer than the newest
    // sample read the newest sample.
    t_window  n_win;
    t_win_ctl n_ctl;
    logic [OFF_W-1:0] span;
    logic [OFF_W-1:0] off;

    always_comb begin
        span = OFF_W'(issue_d) + OFF_W'(half);
        for (int t = 0; t < MAX_WINDOW; t++) begin
            off          = (OFF_W'(t) > span) ? '0 : span - OFF_W'(t);
            n_win[t]     = n_hist[off];
            n_ctl.mask[t] = (OFF_W'(t) <= OFF_W'({half, 1'b0}));
        end
        n_ctl.half = half;
        n_ctl.last = issue_last;
    end

    logic     r_s1_valid;
    t_window  r_s1_win;
    t_win_ctl r_s1_ctl;
    logic     med_ready;

    assign s1_ready = !r_s1_valid || med_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && issue) begin
            r_s1_win <= n_win;
            r_s1_ctl <= n_ctl;
        end
    end

    // ---------------- median pipe and output register ----------------
    t_sample med_data;

    smf_median u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .o_ready (med_ready),
        .i_win   (r_s1_win),
        .i_ctl   (r_s1_ctl),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (med_data),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = med_data;

endmodule

// ===== hdl/smf_cell.sv =====
// One history cell of the sample shift chain.
// Depends on smf_pkg.
module smf_cell (
    input  logic             i_clk,
    input  logic             i_load,     // first sample: every cell takes it
    input  logic             i_shift,    // later samples: take neighbor
    input  smf_pkg::t_sample i_sample,
    input  smf_pkg::t_sample i_prev,
    output smf_pkg::t_sample o_val,
    output smf_pkg::t_sample o_next
);
    import smf_pkg::*;

    t_sample r_val;
    t_sample n_val;

    always_comb begin
        n_val = r_val;
        if (i_load) begin
            n_val = i_sample;
        end else if (i_shift) begin
            n_val = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val  = r_val;
    assign o_next = n_val;

endmodule

// ===== hdl/smf_median.sv =====
// Median pipe: registered pairwise compares, then rank select into the
// output register. Depends on smf_pkg.
module smf_median (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  smf_pkg::t_window  i_win,
    input  smf_pkg::t_win_ctl i_ctl,
    output logic              o_valid,
    input  logic              i_ready,
    output smf_pkg::t_sample  o_data,
    output logic              o_last
);
    import smf_pkg::*;

    logic                                  r_s2_valid;
    t_window                               r_s2_win;
    t_win_ctl                              r_s2_ctl;
    logic [MAX_WINDOW-1:0][MAX_WINDOW-1:0] r_s2_less;
    logic [MAX_WINDOW-1:0][MAX_WINDOW-1:0] n_less;

    logic    r_o_valid;
    t_sample r_o_data;
    logic    r_o_last;
    t_sample n_med;

    logic out_ready;
    logic s2_ready;

    assign out_ready = !r_o_valid || i_ready;
    assign s2_ready  = !r_s2_valid || out_ready;
    assign o_ready   = s2_ready;

    // less[i][j]: slot i strictly below slot j
    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            for (int j = 0; j < MAX_WINDOW; j++) begin
                n_less[i][j] = (i != j) && ($signed(i_win[i]) < $signed(i_win[j]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && i_valid) begin
            r_s2_win  <= i_win;
            r_s2_ctl  <= i_ctl;
            r_s2_less <= n_less;
        end
    end

    // Stable rank: ties broken by slot order, so exactly one slot has rank h.
    always_comb begin
        logic [RANK_W-1:0] rank;
        n_med = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            rank = '0;
            for (int j = 0; j < MAX_WINDOW; j++) begin
                if (r_s2_ctl.mask[j]) begin
                    if (j < i && !r_s2_less[i][j]) begin
                        rank = rank + 1'b1;
                    end else if (j > i && r_s2_less[j][i]) begin
                        rank = rank + 1'b1;
                    end
                end
            end
            if (r_s2_ctl.mask[i] && rank == RANK_W'(r_s2_ctl.half)) begin
                n_med = n_med | r_s2_win[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ready) begin
            r_o_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s2_valid) begin
            r_o_data <= n_med;
            r_o_last <= r_s2_ctl.last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_last  = r_o_last;

endmodule

// ===== test/tb_sliding_median_filter_unit.sv =====
// Self-checking bench for sliding_median_filter_unit: directed edge cases, then
// random sequences under several idle/stall mixes and every window setting.
// Depends on smf_pkg and the filter RTL only.
`timescale 1ns / 1ps

module tb_sliding_median_filter_unit;
    import smf_pkg::*;

    localparam int LATENCY        = 3;
    localparam int HOLDOFF_CYCLES = 60;
    localparam int PHASE_ITEMS    = 9;
    localparam int PHASE_COUNT    = 8;
    localparam int LIMIT_NS       = 2_000_000;

    localparam int SENDER_IDLE [4]   = '{0, 87, 0, 36};
    localparam int RECEIVER_STALL [4] = '{0, 0, 87, 36};
    localparam logic [CFG_W-1:0] PHASE_WINDOWS [PHASE_COUNT] = '{7, 1, 4, 0, 5, 2, 6, 3};

    typedef struct packed {
        t_sample value;
        logic    last;
    } t_filt_result;

    // Tracks the filter state and holds the medians still owed by the block.
    class t_median_ledger;
        logic [CFG_W-1:0] window_reg;
        t_sample          history [MAX_WINDOW];
        int               taken;
        bit               seq_active;
        t_filt_result     pending_medians [$];
        int               mismatches;
        int               samples;
        int               results;

        function new();
            window_reg = CFG_RESET;
            foreach (history[i]) history[i] = '0;
            taken      = 0;
            seq_active = 1'b0;
            mismatches = 0;
            samples    = 0;
            results    = 0;
        endfunction

        function void set_window(logic [CFG_W-1:0] w);
            window_reg = w;
        endfunction

        function int half_span();
            int h;
            h = (window_reg == 0) ? 0 : (int'(window_reg) - 1) / 2;
            if (h > HALF_MAX) h = HALF_MAX;
            return h;
        endfunction

        // median of the window centered 'delay' samples behind the newest one
        function t_sample median_around(int delay, int h);
            t_sample win [MAX_WINDOW];
            t_sample key;
            int      n;
            int      off;
            int      j;
            n = 2 * h + 1;
            for (int t = 0; t < n; t++) begin
                off = delay + h - t;
                if (off < 0) off = 0;
                if (off > MAX_WINDOW - 1) off = MAX_WINDOW - 1;
                win[t] = history[off];
            end
            for (int i = 1; i < n; i++) begin
                key = win[i];
                j   = i;
                while (j > 0 && win[j-1] > key) begin
                    win[j] = win[j-1];
                    j--;
                end
                win[j] = key;
            end
            return win[h];
        endfunction

        function void take_sample(t_sample s, logic last);
            t_filt_result r;
            int           h;
            int           k;
            int           d;
            h = half_span();
            samples++;
            if (!seq_active) begin
                // first sample of a sequence replicates into the whole history
                foreach (history[i]) history[i] = s;
                taken      = 0;
                seq_active = 1'b1;
            end else begin
                for (int i = MAX_WINDOW - 1; i > 0; i--) history[i] = history[i-1];
                history[0] = s;
            end
            k = taken;
            if (taken < MAX_WINDOW) taken++;
            if (!last) begin
                if (k >= h) begin
                    r.value = median_around(h, h);
                    r.last  = 1'b0;
                    pending_medians = {pending_medians, r};
                end
                return;
            end
            // flush every pending position, oldest first
            d = (k < h) ? k : h;
            while (d >= 0) begin
                r.value = median_around(d, h);
                r.last  = (d == 0);
                pending_medians = {pending_medians, r};
                d--;
            end
            seq_active = 1'b0;
            taken      = 0;
        endfunction

        task flag_mismatch(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task match_output(t_sample v, logic last);
            t_filt_result want;
            results++;
            if (pending_medians.size() == 0) begin
                flag_mismatch($sformatf("result %0d (last %0b) with nothing expected", v, last));
                return;
            end
            want = pending_medians.pop_front();
            if (v !== want.value)
                flag_mismatch($sformatf("filtered_value %0d, expected %0d", v, want.value));
            if (last !== want.last)
                flag_mismatch($sformatf("last_of_sequence %0b, expected %0b", last, want.last));
        endtask

        function int pending();
            return pending_medians.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [SAMPLE_BITS-1:0] i_s_tdata;   // [23:0] sample_value
    logic                   i_s_tlast;   // last_in_sequence
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [SAMPLE_BITS-1:0] o_m_tdata;   // [23:0] filtered_value
    logic                   o_m_tlast;   // last_of_sequence
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data;

    t_median_ledger ledger = new();

    int         sender_idle_pct;
    int         receiver_stall_pct;
    int         holdoff_token;
    int         holdoff_taken;
    int         hold_left;
    logic [7:0] windows_used;

    sliding_median_filter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout: %0d results still expected", ledger.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

    // transaction monitor: config, input and output handshakes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                ledger.set_window(i_cfg_data);
                windows_used[i_cfg_data] = 1'b1;
            end
            if (i_s_tvalid && o_s_tready)
                ledger.take_sample(t_sample'(i_s_tdata), i_s_tlast);
            if (o_m_tvalid && i_m_tready)
                ledger.match_output(t_sample'(o_m_tdata), o_m_tlast);
        end
    end

    // output side: random stalls, plus a long hold-off on request
    initial begin
        holdoff_taken = 0;
        hold_left     = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_token != holdoff_taken) begin
                holdoff_taken = holdoff_token;
                hold_left     = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    function automatic t_sample pick_sample();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? t_sample'(24'h800000) : t_sample'(24'h7FFFFF);
            1, 2, 3: return t_sample'(int'($urandom_range(8)) - 4);  // near zero, many ties
            default: return t_sample'($urandom);
        endcase
    endfunction

    task send_sample(input t_sample v, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task write_window(input logic [CFG_W-1:0] w);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every owed median, then let the pipe settle; the first edge
    // makes sure the monitor has noted the final input transaction
    task drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task run_random_phase(input int phase);
        int sent;
        int len;
        sender_idle_pct    = SENDER_IDLE[phase % 4];
        receiver_stall_pct = RECEIVER_STALL[phase % 4];
        write_window(PHASE_WINDOWS[phase]);
        if (phase == 0) holdoff_token <= holdoff_token + 1;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            case ($urandom_range(9))
                0:       len = 1;
                1, 2:    len = $urandom_range(11, 20);
                default: len = $urandom_range(2, 10);
            endcase
            for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
            sent += len;
        end
        drain();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tlast   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        holdoff_token      = 0;
        windows_used       = 8'h80;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window of 7: single-sample sequence, extremes, short sequence
        send_sample(t_sample'(24'h7FFFFF), 1'b1);
        send_sample(t_sample'(24'h800000), 1'b0);
        send_sample(t_sample'(0), 1'b0);
        send_sample(t_sample'(24'h7FFFFF), 1'b0);
        send_sample(t_sample'(-1), 1'b0);
        send_sample(t_sample'(1), 1'b1);
        send_sample(t_sample'(100), 1'b0);
        send_sample(t_sample'(-100), 1'b1);
        drain();

        // zero window acts as one: output equals input
        write_window(0);
        send_sample(t_sample'(24'h555555), 1'b0);
        send_sample(t_sample'(24'hAAAAAA), 1'b0);
        send_sample(t_sample'(-7), 1'b1);
        drain();

        // even window rounds down, then a narrower window mid-sequence
        write_window(6);
        send_sample(t_sample'(5), 1'b0);
        send_sample(t_sample'(-3), 1'b0);
        send_sample(t_sample'(5), 1'b0);
        send_sample(t_sample'(9), 1'b0);
        drain();
        write_window(3);
        send_sample(t_sample'(24'h800000), 1'b0);
        send_sample(t_sample'(2), 1'b1);
        drain();

        write_window(2);
        send_sample(t_sample'(42), 1'b0);
        send_sample(t_sample'(-42), 1'b1);
        drain();

        for (int p = 0; p < PHASE_COUNT; p++) run_random_phase(p);

        if (ledger.pending() != 0)
            ledger.flag_mismatch($sformatf("%0d results never arrived", ledger.pending()));
        $display("covered %0d samples and %0d medians, window settings used %b",
                 ledger.samples, ledger.results, windows_used);
        $display("idle mixes: none, sender, receiver, both; one %0d-cycle output hold-off",
                 HOLDOFF_CYCLES);
        if (ledger.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/smf_pkg.sv
hdl/smf_cell.sv
hdl/smf_median.sv
hdl/sliding_median_filter_unit.sv
test/tb_sliding_median_filter_unit.sv
